// ===== rtl/core/bsa_pkg.sv =====
// Shared types, constants and helper functions of the bitmap slot allocator.
package bsa_pkg;

  localparam int MAP_WORDS = 16;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = 10;
  localparam int FUNC_W    = 3;
  localparam int CAP_W     = 11;
  localparam int INDEX_LIMIT = 1024;
  localparam int CAP_LIMIT =
    (MAP_WORDS * WORD_BITS < INDEX_LIMIT) ? MAP_WORDS * WORD_BITS : INDEX_LIMIT;
  localparam int MW        = WORD_AW + CAP_W + 1;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [FUNC_W-1:0] FN_TEST  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CLR   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLRALL = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FIND  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd5;

  // Configuration register indexes.
  localparam logic REG_BITS_IN_USE = 1'b0;

  typedef enum logic [2:0] {
    K_BIT,
    K_ERR,
    K_CLR,
    K_SCAN,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIT,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic bit_exec;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  scan_hit;
    logic  scan_last;
    logic  out_free;
  } sts_t;

  typedef struct packed {
    logic             bit_was_set;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             index_error;
  } rsp_t;

  // Bits of word w that lie below the capacity.
  function automatic logic [WORD_BITS-1:0] usable_mask(
    input logic [WORD_AW-1:0] w,
    input logic [CAP_W-1:0]   cap
  );
    logic [MW-1:0] base;
    logic [MW-1:0] capx;
    logic [MW-1:0] left;
    base = MW'(w) << BIT_W;
    capx = MW'(cap);
    left = capx - base;
    if (base >= capx) begin
      return '0;
    end else if (left >= MW'(WORD_BITS)) begin
      return '1;
    end else begin
      return (64'd1 << left[BIT_W-1:0]) - 64'd1;
    end
  endfunction

  // Position of the lowest set bit; zero when nothing is set.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = BIT_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/bsa_if.sv =====
// Request and result channel interfaces of the bitmap slot allocator.
interface bsa_req_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  bit_addr;

  modport source (output valid, func, bit_addr, input ready);
  modport sink   (input valid, func, bit_addr, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             bit_was_set;
  logic             found;
  logic [IDX_W-1:0] found_index;
  logic             index_error;

  modport source (output valid, bit_was_set, found, found_index, index_error,
                  input ready);
  modport sink   (input valid, bit_was_set, found, found_index, index_error,
                  output ready);
endinterface

// ===== rtl/core/bsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bsa_ctrl.sv =====
// Sequencing state machine of the bitmap slot allocator.
module bsa_ctrl import bsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (sts.kind)
            K_BIT:   state_nxt = S_BIT;
            K_SCAN:  state_nxt = S_SCAN;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_BIT: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (sts.scan_hit || sts.scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.bit_exec  = (state_r == S_BIT);
    cmd.scan_step = (state_r == S_SCAN);
    cmd.out_load  = (state_r == S_DONE) && sts.out_free;
  end

endmodule

// ===== rtl/core/bsa_dp.sv =====
// Datapath of the bitmap slot allocator: word store, scan, result registers.
module bsa_dp import bsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_bit_addr,
  input  logic [CAP_W-1:0]  bits_in_use,
  output logic              out_valid,
  input  logic              out_ready,
  output rsp_t              out_data
);

  logic [FUNC_W-1:0]    func_r;
  logic [BIT_W-1:0]     bsel_r;
  logic [WORD_AW-1:0]   chk_r;
  logic [MAP_WORDS-1:0] wvld_r;
  logic                 rd_vld_r;
  rsp_t                 res_r;
  rsp_t                 out_r;
  logic                 out_valid_r;

  logic [CAP_W-1:0]     cap;
  logic [WORD_AW-1:0]   in_word;
  logic [WORD_AW-1:0]   raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] umask;
  logic [WORD_BITS-1:0] cand;
  logic [BIT_W-1:0]     hit_pos;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;
  logic                 is_alloc;
  logic                 hit;

  // Capacity saturated to what the store and the index field can hold.
  assign cap = (bits_in_use > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : bits_in_use;

  assign in_word = WORD_AW'(in_bit_addr >> BIT_W);

  always_comb begin
    sts.kind = K_NOP;
    if (in_func <= FN_CLR) begin
      sts.kind = ({1'b0, in_bit_addr} >= cap) ? K_ERR : K_BIT;
    end else if (in_func == FN_CLRALL) begin
      sts.kind = K_CLR;
    end else if (in_func == FN_FIND || in_func == FN_ALLOC) begin
      sts.kind = K_SCAN;
    end
    sts.scan_hit  = hit;
    sts.scan_last = (umask == '0) || (chk_r == WORD_AW'(MAP_WORDS - 1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    if (cmd.accept) begin
      raddr = (in_func <= FN_CLR) ? in_word : '0;
    end else if (cmd.scan_step) begin
      raddr = chk_r + 1'b1;
    end else begin
      raddr = chk_r;
    end
  end

  // Words never written since the last clear read as zero.
  assign rd_word  = rd_vld_r ? ram_rdata : '0;
  assign bit_mask = 64'd1 << bsel_r;
  assign is_alloc = (func_r == FN_ALLOC);
  assign umask    = usable_mask(chk_r, cap);
  assign cand     = is_alloc ? (~rd_word & umask) : (rd_word & umask);
  assign hit      = (cand != '0);
  assign hit_pos  = lowest_set(cand);

  always_comb begin
    we    = 1'b0;
    wdata = rd_word;
    if (cmd.bit_exec && func_r != FN_TEST) begin
      we    = 1'b1;
      wdata = (func_r == FN_SET) ? (rd_word | bit_mask) : (rd_word & ~bit_mask);
    end else if (cmd.scan_step && hit && is_alloc) begin
      we    = 1'b1;
      wdata = rd_word | (64'd1 << hit_pos);
    end
  end

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WORD_AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (chk_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && sts.kind == K_CLR) begin
        wvld_r <= '0;
      end else if (we) begin
        wvld_r[chk_r] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= wvld_r[raddr];
    if (cmd.accept) begin
      func_r <= in_func;
      bsel_r <= in_bit_addr[BIT_W-1:0];
      chk_r  <= raddr;
      res_r  <= '{bit_was_set: 1'b0, found: 1'b0, found_index: '0,
                  index_error: (sts.kind == K_ERR)};
    end
    if (cmd.bit_exec) begin
      res_r.bit_was_set <= (func_r == FN_TEST) && ((rd_word & bit_mask) != '0);
    end
    if (cmd.scan_step) begin
      if (hit) begin
        res_r.found       <= 1'b1;
        res_r.found_index <= IDX_W'({chk_r, hit_pos});
      end else begin
        chk_r <= chk_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/bitmap_slot_allocator.sv =====
// Bitmap slot allocator: a cleared-at-reset bit map with test, set, clear,
// clear-all, find-first-set and allocate-first-clear requests, one result word
// per request word. Test, set and clear pass through a bit state on their way
// to the done state; an out-of-range index, clear all and unused codes go to
// the done state directly. A search examines 64-bit map words from the lowest
// up and stops at the first match, at the first word wholly above the capacity
// or at the last of the sixteen words: words are read one per cycle from the
// single read port of the word store, and a priority encoder picks the lowest
// match inside each word. One request is worked on at a time; the next request
// word is taken the cycle after the previous result has moved into the output
// register, even while that result still waits for the consumer.
// Capacity is the bits_in_use register at byte address 0 (reset 1024); it
// should only be written while the block is idle.
module bitmap_slot_allocator import bsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bsa_req_if.sink     in_bus,
  bsa_rsp_if.source   out_bus,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CAP_W-1:0] bits_in_use_r;
  logic             cfg_wr;
  logic             cfg_hit;
  cmd_t             cmd;
  sts_t             sts;
  rsp_t             out_data;
  logic             out_valid;

  // Address bit 2 selects the register; only register 0 exists.
  assign cfg_hit    = (cfg_paddr[2] == REG_BITS_IN_USE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? 32'(bits_in_use_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= CAP_RESET;
    end else if (cfg_wr) begin
      bits_in_use_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsa_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_bus.func),
    .in_bit_addr  (in_bus.bit_addr),
    .bits_in_use  (bits_in_use_r),
    .out_valid    (out_valid),
    .out_ready    (out_bus.ready),
    .out_data     (out_data)
  );

  // The result word leaves straight from the datapath's output register.
  assign out_bus.valid       = out_valid;
  assign out_bus.bit_was_set = out_data.bit_was_set;
  assign out_bus.found       = out_data.found;
  assign out_bus.found_index = out_data.found_index;
  assign out_bus.index_error = out_data.index_error;

endmodule

// ===== rtl/core/bsa_checker.sv =====
// Port-level checker of the bitmap slot allocator and its bind statement.
module bsa_checker import bsa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             bit_was_set,
  input logic             found,
  input logic [IDX_W-1:0] found_index,
  input logic             index_error
);

  // Nothing is offered to the consumer right after a reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // Requests are handled one at a time, so a new one is not taken at once.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(found) &&
      $stable(found_index) && $stable(bit_was_set) && $stable(index_error)))
    else $error("stalled result word changed");

  // An error result or a failed search carries no other information.
  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((!found || !index_error) && (found || found_index == '0) &&
      (!index_error || !bit_was_set) && (!found || !bit_was_set)))
    else $error("inconsistent result fields");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .bit_was_set (out_bus.bit_was_set),
  .found       (out_bus.found),
  .found_index (out_bus.found_index),
  .index_error (out_bus.index_error)
);

// ===== verif/bitmap_slot_allocator_test.sv =====
// Self-checking testbench of the bitmap slot allocator with a bit-exact shadow map.
`timescale 1ns / 100ps

module bitmap_slot_allocator_test import bsa_pkg::*; ();

  // The two spare function codes are accepted and must answer with an all-zero word.
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  // Capacity register address: register index times four bytes.
  localparam logic [2:0] CAP_ADDR = 3'({REG_BITS_IN_USE, 2'b00});

  // Margin that covers any word still in flight after a search over the full map.
  localparam int SETTLE_CYCLES = 24;
  localparam int LIMIT_NS      = 5_000_000;
  localparam int PHASE_WORDS   = 150;

  localparam rsp_t RSP_ZERO    = '0;
  localparam rsp_t RSP_ERR     = '{1'b0, 1'b0, 10'd0, 1'b1};
  localparam rsp_t RSP_WAS_SET = '{1'b1, 1'b0, 10'd0, 1'b0};
  localparam rsp_t RSP_FOUND_0 = '{1'b0, 1'b1, 10'd0, 1'b0};
  localparam rsp_t RSP_FOUND_1 = '{1'b0, 1'b1, 10'd1, 1'b0};

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

  // One row of the directed plan. A ROW_CAP row rewrites the capacity once the
  // block has gone quiet; a ROW_REQ row sends one request word. Rows with
  // typed set carry their own expected result; the rest rely on the shadow map.
  typedef struct {
    row_kind_t         kind;
    logic [CAP_W-1:0]  cap;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  idx;
    bit                typed;
    rsp_t              want;
  } plan_row_t;

  localparam int PLAN_ROWS = 30;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    // Fresh map at full capacity.
    '{ROW_REQ, 11'd0,    FN_TEST,     10'd0,    1'b1, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_ALLOC,    10'd0,    1'b1, RSP_FOUND_0},
    '{ROW_REQ, 11'd0,    FN_ALLOC,    10'd0,    1'b1, RSP_FOUND_1},
    '{ROW_REQ, 11'd0,    FN_SET,      10'd1023, 1'b0, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_TEST,     10'd1023, 1'b1, RSP_WAS_SET},
    '{ROW_REQ, 11'd0,    FN_CLR,      10'd0,    1'b0, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_FIND,     10'd0,    1'b1, RSP_FOUND_1},
    '{ROW_REQ, 11'd0,    FN_SPARE_LO, 10'd0,    1'b1, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_SPARE_HI, 10'd1023, 1'b1, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_CLRALL,   10'd0,    1'b1, RSP_ZERO},
    // Empty map: nothing to find.
    '{ROW_REQ, 11'd0,    FN_FIND,     10'd0,    1'b1, RSP_ZERO},
    // Capacity zero: every index is out of range and searches see no bits.
    '{ROW_CAP, 11'd0,    FN_TEST,     10'd0,    1'b0, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_TEST,     10'd0,    1'b1, RSP_ERR},
    '{ROW_REQ, 11'd0,    FN_SET,      10'd1023, 1'b1, RSP_ERR},
    '{ROW_REQ, 11'd0,    FN_FIND,     10'd0,    1'b1, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_ALLOC,    10'd0,    1'b1, RSP_ZERO},
    // One-word capacity: index 64 is the first one past the end.
    '{ROW_CAP, 11'd64,   FN_TEST,     10'd0,    1'b0, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_SET,      10'd64,   1'b1, RSP_ERR},
    '{ROW_REQ, 11'd0,    FN_SET,      10'd63,   1'b0, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_ALLOC,    10'd0,    1'b1, RSP_FOUND_0},
    // All-ones register value saturates to the full map.
    '{ROW_CAP, 11'd2047, FN_TEST,     10'd0,    1'b0, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_ALLOC,    10'd0,    1'b1, RSP_FOUND_1},
    '{ROW_REQ, 11'd0,    FN_CLRALL,   10'd0,    1'b1, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_SET,      10'd1023, 1'b0, RSP_ZERO},
    // A bit left set above a lowered capacity is invisible but kept.
    '{ROW_CAP, 11'd1023, FN_TEST,     10'd0,    1'b0, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_FIND,     10'd0,    1'b1, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_TEST,     10'd1023, 1'b1, RSP_ERR},
    '{ROW_CAP, 11'd1024, FN_TEST,     10'd0,    1'b0, RSP_ZERO},
    '{ROW_REQ, 11'd0,    FN_TEST,     10'd1023, 1'b1, RSP_WAS_SET},
    '{ROW_REQ, 11'd0,    FN_ALLOC,    10'd0,    1'b1, RSP_FOUND_0}
  };

  // Capacities of the random phases; -1 picks a small random one, -2 any value.
  int phase_caps [11] = '{1, 3, 64, 65, 2047, 0, 127, 1024, -1, -1, -2};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bsa_req_if req_bus ();
  bsa_rsp_if rsp_bus ();

  bitmap_slot_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (req_bus),
    .out_bus     (rsp_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the block: the bit map and the capacity register.
  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS] = '{default: '0};
  logic [CAP_W-1:0]     shadow_cap = CAP_RESET;

  // Results predicted at acceptance, oldest first.
  rsp_t awaited_results [$];
  int   mismatch_count = 0;

  // Sender burst state and receiver stall pattern state.
  int   burst_left = 0;
  int   gap_left   = 0;
  int   hold_left  = 0;
  logic ready_level = 1'b0;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // The register value is 11 bits wide, but the map and the index both stop at
  // CAP_LIMIT bits, so anything above that behaves like CAP_LIMIT.
  function automatic int effective_cap();
    return (int'(shadow_cap) > CAP_LIMIT) ? CAP_LIMIT : int'(shadow_cap);
  endfunction

  // Applies one request word to the shadow map and returns the result word it must produce.
  function automatic rsp_t predict_result(input logic [FUNC_W-1:0] f,
                                          input logic [IDX_W-1:0] ix);
    rsp_t                 res;
    int                   eff;
    int                   left;
    int                   pos;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] hits;
    res = '0;
    eff = effective_cap();
    if (f == FN_TEST || f == FN_SET || f == FN_CLR) begin
      if (int'(ix) >= eff) begin
        res.index_error = 1'b1;
      end else begin
        case (f)
          FN_TEST: begin
            res.bit_was_set = shadow_map[ix[IDX_W-1:BIT_W]][ix[BIT_W-1:0]];
          end
          FN_SET: begin
            shadow_map[ix[IDX_W-1:BIT_W]][ix[BIT_W-1:0]] = 1'b1;
          end
          default: begin
            shadow_map[ix[IDX_W-1:BIT_W]][ix[BIT_W-1:0]] = 1'b0;
          end
        endcase
      end
    end else if (f == FN_CLRALL) begin
      // Clear all reaches every word, also those above the capacity.
      foreach (shadow_map[w]) shadow_map[w] = '0;
    end else if (f == FN_FIND || f == FN_ALLOC) begin
      // Scan words from the lowest, stopping at the first word that lies
      // wholly above the capacity or at the first match.
      for (int w = 0; w < MAP_WORDS && w * WORD_BITS < eff && !res.found; w++) begin
        left = eff - w * WORD_BITS;
        mask = (left >= WORD_BITS) ? '1 : ((64'd1 << left) - 64'd1);
        hits = (f == FN_FIND) ? (shadow_map[w] & mask) : (~shadow_map[w] & mask);
        if (hits != '0) begin
          pos = 0;
          for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (hits[p]) begin
              pos = p;
            end
          end
          if (f == FN_ALLOC) begin
            shadow_map[w][pos] = 1'b1;
          end
          res.found       = 1'b1;
          res.found_index = IDX_W'(w * WORD_BITS + pos);
        end
      end
    end
    return res;
  endfunction

  // Sends one request word, honoring the current burst and gap. The shadow map
  // is updated at the accepting edge; a typed row substitutes its own result.
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] ix,
                              input bit typed, input rsp_t want);
    rsp_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
    end
    while (gap_left > 0) begin
      @(negedge clk);
      req_bus.valid = 1'b0;
      gap_left--;
    end
    @(negedge clk);
    req_bus.valid    = 1'b1;
    req_bus.func     = f;
    req_bus.bit_addr = ix;
    do @(posedge clk); while (!req_bus.ready);
    predicted = predict_result(f, ix);
    awaited_results.push_back(typed ? want : predicted);
    burst_left--;
  endtask

  // Stops the sender and waits until every predicted word has come out and
  // the block has had time to finish anything still running.
  task automatic drain_block();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the capacity register and reads it back over the APB port.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CAP_ADDR;
    cfg_pwdata  = 32'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow_cap = value;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(value)) begin
      report_mismatch("capacity read back", int'(cfg_prdata), int'(value));
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // The receiver alternates between long free-flowing stretches, long stalls
  // and short random toggling, so results meet back-pressure of varied lengths.
  always @(negedge clk) begin
    if (hold_left == 0) begin
      case ($urandom_range(9))
        0: begin
          ready_level = 1'b1;
          hold_left   = $urandom_range(120, 40);
        end
        1, 2: begin
          ready_level = 1'b0;
          hold_left   = $urandom_range(20, 5);
        end
        default: begin
          ready_level = 1'($urandom_range(1));
          hold_left   = $urandom_range(4, 1);
        end
      endcase
    end else begin
      hold_left--;
    end
    rsp_bus.ready <= ready_level;
  end

  // Every accepted result word is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding", 1, 0);
      end else begin
        want = awaited_results.pop_front();
        if (rsp_bus.bit_was_set !== want.bit_was_set) begin
          report_mismatch("bit_was_set", int'(rsp_bus.bit_was_set), int'(want.bit_was_set));
        end
        if (rsp_bus.found !== want.found) begin
          report_mismatch("found", int'(rsp_bus.found), int'(want.found));
        end
        if (rsp_bus.found_index !== want.found_index) begin
          report_mismatch("found_index", int'(rsp_bus.found_index), int'(want.found_index));
        end
        if (rsp_bus.index_error !== want.index_error) begin
          report_mismatch("index_error", int'(rsp_bus.index_error), int'(want.index_error));
        end
      end
    end
  end

  initial begin : stimulus
    int                cap_pick;
    int                eff;
    int                r;
    logic [FUNC_W-1:0] f;
    logic [IDX_W-1:0]  ix;

    rst_n            = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.func     = FN_TEST;
    req_bus.bit_addr = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = CAP_ADDR;
    cfg_pwdata       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed plan: extremes of both fields, every function code and the
    // capacity corner cases, starting from the reset state.
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CAP) begin
        drain_block();
        write_capacity(directed_plan[i].cap);
      end else begin
        send_request(directed_plan[i].func, directed_plan[i].idx,
                     directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases. Allocation dominates so small maps run full, clear all
    // is rare so the map keeps its contents, and most indices fall inside
    // the capacity with the rest spread over the whole field.
    foreach (phase_caps[p]) begin
      if (phase_caps[p] == -1) begin
        cap_pick = $urandom_range(200, 2);
      end else if (phase_caps[p] == -2) begin
        cap_pick = $urandom_range(2047, 0);
      end else begin
        cap_pick = phase_caps[p];
      end
      drain_block();
      write_capacity(CAP_W'(cap_pick));
      eff = effective_cap();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(99);
        if (r < 35) begin
          f = FN_ALLOC;
        end else if (r < 50) begin
          f = FN_SET;
        end else if (r < 62) begin
          f = FN_CLR;
        end else if (r < 76) begin
          f = FN_TEST;
        end else if (r < 90) begin
          f = FN_FIND;
        end else if (r < 92) begin
          f = FN_CLRALL;
        end else if (r < 95) begin
          f = ($urandom_range(1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
        end else begin
          f = FUNC_W'($urandom);
        end
        if (eff > 0 && $urandom_range(4) != 0) begin
          ix = IDX_W'($urandom_range(eff - 1, 0));
        end else begin
          ix = IDX_W'($urandom);
        end
        send_request(f, ix, 1'b0, RSP_ZERO);
      end
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
